FILE: rtl/polynomial_path_closest_point_assert.svh
// Assertion macros shared by the closest point block.
// Each macro expects a clock named clk in scope; PPCP_ASSERT also expects an active-low rst_n.
`ifndef POLYNOMIAL_PATH_CLOSEST_POINT_ASSERT_SVH
`define POLYNOMIAL_PATH_CLOSEST_POINT_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset.
`define PPCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every rising clock edge, reset included.
`define PPCP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPCP_ASSERT(lbl, prop, msg)
`define PPCP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/ppcp_pkg.sv
`timescale 1ns / 1ps

package ppcp_pkg;

  localparam int MAX_ORDER  = 5;
  localparam int FRAC_BITS  = 24;
  localparam int NCOEF      = MAX_ORDER + 1;
  localparam int NSCR       = 2 * MAX_ORDER;
  localparam int STEP_SHIFT = 32 - FRAC_BITS;

  localparam logic signed [63:0] LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam logic AXIS_X   = 1'b0;
  localparam logic AXIS_Y   = 1'b1;

  localparam logic [1:0] REG_PATH_LENGTH    = 2'd0;
  localparam logic [1:0] REG_STOP_TOLERANCE = 2'd1;
  localparam logic [1:0] REG_MAX_ITERATIONS = 2'd2;
  localparam logic [1:0] REG_PATH_ORDER     = 2'd3;

  typedef struct packed {
    logic               opcode;
    logic               axis;
    logic [2:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } ppcp_in_t;

  typedef struct packed {
    logic [30:0] path_param;
    logic        converged;
  } ppcp_out_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] g;
    logic signed [63:0] h;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic        neg;
  } div_rsp_t;

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [63:0] signed_of(input logic [63:0] m, input logic neg);
    logic [63:0] c;
    c = (m > 64'(LIM)) ? 64'(LIM) : m;
    return neg ? -$signed(c) : $signed(c);
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] sum;
    sum = 65'(a) + 65'(b);
    if (sum > 65'(LIM)) return LIM;
    else if (sum < -65'(LIM)) return -LIM;
    else return sum[63:0];
  endfunction

  function automatic logic signed [63:0] scale(input logic signed [63:0] a,
                                               input logic [3:0] k);
    logic [63:0] m;
    logic [67:0] p;
    m = mag(a);
    p = 68'(m) * 68'(k);
    return signed_of((p > 68'(LIM)) ? 64'(LIM) : p[63:0], a[63]);
  endfunction

  function automatic logic signed [63:0] trunc_q(input logic signed [63:0] p);
    return signed_of(mag(p) >> FRAC_BITS, p[63]);
  endfunction

  function automatic logic signed [31:0] center(input logic signed [31:0] c,
                                                input logic signed [31:0] p);
    logic signed [32:0] v;
    v = 33'(c) - 33'(p);
    if (v > 33'sd2147483647) return 32'sh7FFF_FFFF;
    else if (v < -33'sd2147483648) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

endpackage

FILE: rtl/ppcp_div.sv
`timescale 1ns / 1ps
`include "polynomial_path_closest_point_assert.svh"

// Newton step magnitude: min(|g| * 2^FRAC_BITS / |h|, 2^32 - 1), one quotient bit a cycle.
module ppcp_div (
  input  logic                clk,
  input  logic                rst_n,
  input  ppcp_pkg::div_req_t  req,
  output ppcp_pkg::div_rsp_t  rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] nh_r, nh_nxt;
  logic [31:0] nlow_r, nlow_nxt;
  logic [31:0] q_r, q_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] ng, nh;
  logic [64:0] rem2;
  logic        fits;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    nh_nxt   = nh_r;
    nlow_nxt = nlow_r;
    q_nxt    = q_r;
    neg_nxt  = neg_r;
    ng       = ppcp_pkg::mag(req.g);
    nh       = ppcp_pkg::mag(req.h);
    rem2     = {rem_r, nlow_r[31]};
    fits     = rem2 >= {1'b0, nh_r};
    if (req.start) begin
      neg_nxt = (req.g[63] == req.h[63]);
      if (req.g == '0) begin
        q_nxt    = '0;
        done_nxt = 1'b1;
      end else if (req.h == '0 || (ng >> ppcp_pkg::STEP_SHIFT) >= nh) begin
        q_nxt    = '1;
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
        rem_nxt  = ng >> ppcp_pkg::STEP_SHIFT;
        nlow_nxt = 32'(ng << ppcp_pkg::FRAC_BITS);
        nh_nxt   = nh;
        q_nxt    = '0;
        cnt_nxt  = 6'd32;
      end
    end else if (busy_r) begin
      rem_nxt  = fits ? 64'(rem2 - {1'b0, nh_r}) : rem2[63:0];
      q_nxt    = {q_r[30:0], fits};
      nlow_nxt = {nlow_r[30:0], 1'b0};
      cnt_nxt  = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    busy_r <= busy_nxt;
    done_r <= done_nxt;
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    nh_r   <= nh_nxt;
    nlow_r <= nlow_nxt;
    q_r    <= q_nxt;
    neg_r  <= neg_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end
  end

  assign rsp = '{done: done_r, quot: q_r, neg: neg_r};

  `PPCP_ASSERT(a_div_start_idle, req.start |-> !busy_r, "divider started while busy")
  `PPCP_ASSERT(a_div_done_idle, done_r |-> !busy_r, "divider done while still busy")
  `PPCP_ASSERT(a_div_cnt_range, busy_r |-> cnt_r != 6'd0 && cnt_r <= 6'd32, "divider count out of range")

endmodule

FILE: rtl/polynomial_path_closest_point.sv
`timescale 1ns / 1ps
`include "polynomial_path_closest_point_assert.svh"

// Closest point on a polynomial path x(s), y(s), found by Newton minimization.
// Commands arrive on in_item and are taken at a rising edge with start high and busy low.
// A write command stores one coefficient (index at most MAX_ORDER) and produces no result.
// A query command builds the derivative coefficients of the squared distance into a
// scratch memory, then runs Newton steps from s = 0. Each step evaluates the first
// and second derivative by Horner's rule through the shared two-half multiply states
// and divides in a bit-serial divider. A query ends when a step converges or when the
// step limit, 100 by default, is reached. busy stays high for the whole query.
// The result is shown on out_item for exactly one cycle with out_valid high; the
// receiver cannot stall, so it must take the transfer in that cycle.
// The user must write registers through cfg_we, cfg_index and cfg_wdata only while busy
// is low; the block itself does not enforce it. Synchronous reset clears the coefficient
// tables to zero, returns to idle and loads the register defaults, with no clearing pass.
module polynomial_path_closest_point (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ppcp_pkg::ppcp_in_t  in_item,
  output logic                out_valid,
  output ppcp_pkg::ppcp_out_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [30:0]         cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_D_RD, S_D_MUL, S_D_ACC, S_D_WR, S_N_START, S_G_INIT,
    S_H_MUL0, S_H_MUL1, S_H_ADD, S_H_ACC, S_DIV_GO, S_DIV
  } state_t;

  // Configuration.
  logic [30:0] path_len_r, path_len_nxt;
  logic [24:0] tol_r, tol_nxt;
  logic [7:0]  max_iter_r, max_iter_nxt;
  logic [2:0]  order_r, order_nxt;

  // Coefficient tables with per-entry valid bits; an entry never written reads as zero.
  logic [31:0] xtab_mem [ppcp_pkg::NCOEF];
  logic [31:0] ytab_mem [ppcp_pkg::NCOEF];
  logic [ppcp_pkg::NCOEF-1:0] xval_r, xval_nxt, yval_r, yval_nxt;
  logic signed [31:0] xa_q, xb_q, ya_q, yb_q;
  logic        tab_we;
  logic [2:0]  j_idx;

  // Scratch memory holding the coefficients of D'(s).
  logic [63:0] scr_mem [ppcp_pkg::NSCR];
  logic [63:0] scr_q;
  logic        scr_we;
  logic [3:0]  scr_waddr, scr_raddr;
  logic [63:0] scr_wdata;

  state_t      state_r, state_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [2:0]  i_r, i_nxt;
  logic [2:0]  n_r, n_nxt;
  logic signed [31:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [63:0] d_r, d_nxt, prx_r, prx_nxt, pry_r, pry_nxt;
  logic [30:0] s_r, s_nxt;
  logic [7:0]  it_r, it_nxt;
  logic        conv_r, conv_nxt;
  logic signed [63:0] acc_r, acc_nxt, coef_r, coef_nxt, mulr_r, mulr_nxt;
  logic signed [63:0] g_r, g_nxt, h_r, h_nxt;
  logic [62:0] pl_r, pl_nxt;
  logic [61:0] ph_r, ph_nxt;
  logic [3:0]  hk_r, hk_nxt;
  logic        second_r, second_nxt;
  logic        out_valid_r, out_valid_nxt;
  ppcp_pkg::ppcp_out_t out_r, out_nxt;

  ppcp_pkg::div_req_t div_req;
  ppcp_pkg::div_rsp_t div_rsp;

  // Combinational helpers.
  logic        accept;
  logic signed [31:0] cxi, cxj, cyi, cyj;
  logic [63:0] macc;
  logic [93:0] full, fsh;
  logic signed [63:0] acc_sum;
  logic signed [33:0] s_sum;
  logic [3:0]  i_end;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign j_idx     = 3'(k_r - 4'(i_r));
  assign tab_we    = accept && in_item.opcode == ppcp_pkg::OP_WRITE &&
                     in_item.coef_index <= 3'(ppcp_pkg::MAX_ORDER);
  assign scr_waddr = 4'(k_r - 4'd1);
  assign scr_wdata = ppcp_pkg::scale(d_r, k_r);
  assign macc      = ppcp_pkg::mag(acc_r);
  assign full      = {ph_r, 32'b0} + 94'(pl_r);
  assign fsh       = full >> ppcp_pkg::FRAC_BITS;
  assign acc_sum   = ppcp_pkg::sat_add(mulr_r, coef_r);
  assign i_end     = (k_r > 4'(ppcp_pkg::MAX_ORDER)) ? 4'(ppcp_pkg::MAX_ORDER) : k_r;
  assign div_req   = '{start: state_r == S_DIV_GO, g: g_r, h: h_r};

  // Centered, order-limited coefficients for the current pair (i, k - i).
  always_comb begin
    cxi = '0;
    cyi = '0;
    cxj = '0;
    cyj = '0;
    if (i_r <= n_r) begin
      cxi = (i_r == '0) ? ppcp_pkg::center(xa_q, px_r) : xa_q;
      cyi = (i_r == '0) ? ppcp_pkg::center(ya_q, py_r) : ya_q;
    end
    if (j_idx <= n_r) begin
      cxj = (j_idx == '0) ? ppcp_pkg::center(xb_q, px_r) : xb_q;
      cyj = (j_idx == '0) ? ppcp_pkg::center(yb_q, py_r) : yb_q;
    end
  end

  always_comb begin
    path_len_nxt  = path_len_r;
    tol_nxt       = tol_r;
    max_iter_nxt  = max_iter_r;
    order_nxt     = order_r;
    xval_nxt      = xval_r;
    yval_nxt      = yval_r;
    state_nxt     = state_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    n_nxt         = n_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    d_nxt         = d_r;
    prx_nxt       = prx_r;
    pry_nxt       = pry_r;
    s_nxt         = s_r;
    it_nxt        = it_r;
    conv_nxt      = conv_r;
    acc_nxt       = acc_r;
    coef_nxt      = coef_r;
    mulr_nxt      = mulr_r;
    g_nxt         = g_r;
    h_nxt         = h_r;
    pl_nxt        = pl_r;
    ph_nxt        = ph_r;
    hk_nxt        = hk_r;
    second_nxt    = second_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    scr_we        = 1'b0;
    scr_raddr     = hk_r;
    s_sum         = '0;

    if (cfg_we) begin
      case (cfg_index)
        ppcp_pkg::REG_PATH_LENGTH:    path_len_nxt = cfg_wdata;
        ppcp_pkg::REG_STOP_TOLERANCE: tol_nxt      = cfg_wdata[24:0];
        ppcp_pkg::REG_MAX_ITERATIONS: max_iter_nxt = cfg_wdata[7:0];
        ppcp_pkg::REG_PATH_ORDER:     order_nxt    = cfg_wdata[2:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_item.opcode == ppcp_pkg::OP_WRITE) begin
            if (tab_we) begin
              if (in_item.axis == ppcp_pkg::AXIS_Y) yval_nxt[in_item.coef_index] = 1'b1;
              else xval_nxt[in_item.coef_index] = 1'b1;
            end
          end else begin
            px_nxt    = in_item.pos_x;
            py_nxt    = in_item.pos_y;
            n_nxt     = (order_r > 3'(ppcp_pkg::MAX_ORDER)) ? 3'(ppcp_pkg::MAX_ORDER) : order_r;
            k_nxt     = 4'd1;
            i_nxt     = '0;
            d_nxt     = '0;
            s_nxt     = '0;
            it_nxt    = '0;
            conv_nxt  = 1'b0;
            state_nxt = S_D_RD;
          end
        end
      end
      // Table reads for the pair are issued here and arrive in S_D_MUL.
      S_D_RD: state_nxt = S_D_MUL;
      S_D_MUL: begin
        prx_nxt   = 64'(cxi) * 64'(cxj);
        pry_nxt   = 64'(cyi) * 64'(cyj);
        state_nxt = S_D_ACC;
      end
      S_D_ACC: begin
        d_nxt = ppcp_pkg::sat_add(d_r, ppcp_pkg::sat_add(ppcp_pkg::trunc_q(prx_r),
                                                         ppcp_pkg::trunc_q(pry_r)));
        if (4'(i_r) == i_end) begin
          state_nxt = S_D_WR;
        end else begin
          i_nxt     = i_r + 3'd1;
          state_nxt = S_D_RD;
        end
      end
      // D' coefficient k-1 is k times the distance coefficient k.
      S_D_WR: begin
        scr_we = 1'b1;
        if (k_r == 4'(ppcp_pkg::NSCR)) begin
          state_nxt = S_N_START;
        end else begin
          k_nxt     = k_r + 4'd1;
          i_nxt     = (k_r + 4'd1 > 4'(ppcp_pkg::MAX_ORDER)) ?
                      3'(k_r + 4'd1 - 4'(ppcp_pkg::MAX_ORDER)) : 3'd0;
          d_nxt     = '0;
          state_nxt = S_D_RD;
        end
      end
      S_N_START: begin
        if (conv_r || it_r >= max_iter_r) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{path_param: s_r, converged: conv_r};
          state_nxt     = S_IDLE;
        end else begin
          scr_raddr  = 4'(ppcp_pkg::NSCR - 1);
          second_nxt = 1'b0;
          state_nxt  = S_G_INIT;
        end
      end
      S_G_INIT: begin
        acc_nxt   = scr_q;
        hk_nxt    = 4'(ppcp_pkg::NSCR - 2);
        scr_raddr = 4'(ppcp_pkg::NSCR - 2);
        state_nxt = S_H_MUL0;
      end
      // Horner step: acc <- trunc(acc * s) + coef, the product split in two halves.
      S_H_MUL0: begin
        coef_nxt  = second_r ? ppcp_pkg::scale(scr_q, hk_r + 4'd1) : scr_q;
        pl_nxt    = 63'(macc[31:0]) * 63'(s_r);
        state_nxt = S_H_MUL1;
      end
      S_H_MUL1: begin
        ph_nxt    = 62'(macc[62:32]) * 62'(s_r);
        state_nxt = S_H_ADD;
      end
      S_H_ADD: begin
        mulr_nxt  = ppcp_pkg::signed_of((fsh > 94'(ppcp_pkg::LIM)) ?
                                        64'(ppcp_pkg::LIM) : fsh[63:0], acc_r[63]);
        state_nxt = S_H_ACC;
      end
      S_H_ACC: begin
        acc_nxt = acc_sum;
        if (hk_r == '0) begin
          if (!second_r) begin
            // First derivative done; the second starts from zero on D' coefficient 9.
            g_nxt      = acc_sum;
            second_nxt = 1'b1;
            acc_nxt    = '0;
            hk_nxt     = 4'(ppcp_pkg::NSCR - 2);
            scr_raddr  = 4'(ppcp_pkg::NSCR - 1);
            state_nxt  = S_H_MUL0;
          end else begin
            h_nxt     = acc_sum;
            state_nxt = S_DIV_GO;
          end
        end else begin
          hk_nxt    = hk_r - 4'd1;
          scr_raddr = second_r ? hk_r : hk_r - 4'd1;
          state_nxt = S_H_MUL0;
        end
      end
      S_DIV_GO: state_nxt = S_DIV;
      S_DIV: begin
        if (div_rsp.done) begin
          s_sum = $signed({3'b000, s_r}) +
                  (div_rsp.neg ? -$signed({2'b00, div_rsp.quot})
                               : $signed({2'b00, div_rsp.quot}));
          if (s_sum < 0) s_nxt = '0;
          else if (s_sum > $signed({3'b000, path_len_r})) s_nxt = path_len_r;
          else s_nxt = s_sum[30:0];
          conv_nxt  = div_rsp.quot < 32'(tol_r);
          it_nxt    = it_r + 8'd1;
          state_nxt = S_N_START;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    path_len_r  <= path_len_nxt;
    tol_r       <= tol_nxt;
    max_iter_r  <= max_iter_nxt;
    order_r     <= order_nxt;
    xval_r      <= xval_nxt;
    yval_r      <= yval_nxt;
    state_r     <= state_nxt;
    out_valid_r <= out_valid_nxt;
    k_r         <= k_nxt;
    i_r         <= i_nxt;
    n_r         <= n_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    d_r         <= d_nxt;
    prx_r       <= prx_nxt;
    pry_r       <= pry_nxt;
    s_r         <= s_nxt;
    it_r        <= it_nxt;
    conv_r      <= conv_nxt;
    acc_r       <= acc_nxt;
    coef_r      <= coef_nxt;
    mulr_r      <= mulr_nxt;
    g_r         <= g_nxt;
    h_r         <= h_nxt;
    pl_r        <= pl_nxt;
    ph_r        <= ph_nxt;
    hk_r        <= hk_nxt;
    second_r    <= second_nxt;
    out_r       <= out_nxt;
    if (!rst_n) begin
      path_len_r  <= '0;
      tol_r       <= 25'd16777;
      max_iter_r  <= 8'd100;
      order_r     <= 3'd5;
      xval_r      <= '0;
      yval_r      <= '0;
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      s_r         <= '0;
      it_r        <= '0;
      conv_r      <= 1'b0;
    end
  end

  // Coefficient tables: one write port, two registered read ports per table.
  always_ff @(posedge clk) begin
    if (tab_we) begin
      if (in_item.axis == ppcp_pkg::AXIS_Y) ytab_mem[in_item.coef_index] <= in_item.coef_value;
      else xtab_mem[in_item.coef_index] <= in_item.coef_value;
    end
    xa_q <= xval_r[i_r]   ? xtab_mem[i_r]   : '0;
    xb_q <= xval_r[j_idx] ? xtab_mem[j_idx] : '0;
    ya_q <= yval_r[i_r]   ? ytab_mem[i_r]   : '0;
    yb_q <= yval_r[j_idx] ? ytab_mem[j_idx] : '0;
  end

  // Scratch memory: every entry is written before the Newton phase reads it.
  always_ff @(posedge clk) begin
    if (scr_we) scr_mem[scr_waddr] <= scr_wdata;
    scr_q <= scr_mem[scr_raddr];
  end

  ppcp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `PPCP_ASSERT_ALWAYS(a_write_no_result,
    (start && !busy && in_item.opcode == ppcp_pkg::OP_WRITE) |=> !out_valid,
    "result transfer after a coefficient write")
  `PPCP_ASSERT(a_result_clamped, out_valid |-> out_item.path_param <= path_len_r,
    "result beyond path length")
  `PPCP_ASSERT(a_div_done_waited, div_rsp.done |-> state_r == S_DIV,
    "divider finished while not awaited")

endmodule

FILE: tb/closest_point_checker.sv
`timescale 1ns / 1ps

// Watches the command, result and register ports, predicts each query answer and
// compares it with what the block returns.
module closest_point_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  ppcp_pkg::ppcp_in_t  in_item,
  input  logic                out_valid,
  input  ppcp_pkg::ppcp_out_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [30:0]         cfg_wdata,
  output int                  errors,
  output int                  pending
);

  localparam longint SAT_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam longint unsigned STEP_LIM = 64'hFFFF_FFFF;

  logic signed [31:0] x_tab [ppcp_pkg::NCOEF];
  logic signed [31:0] y_tab [ppcp_pkg::NCOEF];
  logic [30:0] length_reg;
  logic [24:0] tol_reg;
  logic [7:0]  iter_reg;
  logic [2:0]  order_reg;
  ppcp_pkg::ppcp_out_t answers_due [$];

  assign pending = answers_due.size();

  function automatic longint unsigned absu(longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic longint with_sign(longint unsigned m, bit neg);
    if (m > 64'(SAT_LIM)) m = 64'(SAT_LIM);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint add_sat(longint a, longint b);
    longint r;
    r = a + b;
    if (r > SAT_LIM) return SAT_LIM;
    if (r < -SAT_LIM) return -SAT_LIM;
    return r;
  endfunction

  function automatic longint times_k(longint a, longint unsigned k);
    longint unsigned m;
    m = absu(a);
    if (k != 0 && m > 64'(SAT_LIM) / k) m = 64'(SAT_LIM);
    else m = m * k;
    return with_sign(m, a < 0);
  endfunction

  // Fixed-point product of an accumulator and a nonnegative s, truncated toward zero.
  function automatic longint mul_frac(longint a, longint unsigned s);
    longint unsigned m, hi, lo, r;
    m = absu(a);
    hi = m >> ppcp_pkg::FRAC_BITS;
    lo = m & ((64'd1 << ppcp_pkg::FRAC_BITS) - 1);
    if (s != 0 && hi > 64'(SAT_LIM) / s) r = 64'(SAT_LIM);
    else r = hi * s + ((lo * s) >> ppcp_pkg::FRAC_BITS);
    return with_sign(r, a < 0);
  endfunction

  function automatic longint frac_prod(longint a, longint b);
    longint p;
    p = a * b;
    return with_sign(absu(p) >> ppcp_pkg::FRAC_BITS, p < 0);
  endfunction

  function automatic longint offset(logic signed [31:0] c, logic signed [31:0] p);
    longint v;
    v = longint'(c) - longint'(p);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v;
  endfunction

  function automatic longint newton_delta(longint g, longint h);
    longint unsigned ng, nh, q, r, mq;
    if (g == 0) return 0;
    if (h == 0) return g > 0 ? -longint'(STEP_LIM) : longint'(STEP_LIM);
    ng = absu(g);
    nh = absu(h);
    q = ng / nh;
    r = ng % nh;
    if ((q >> (32 - ppcp_pkg::FRAC_BITS)) != 0) begin
      mq = STEP_LIM;
    end else begin
      mq = q;
      for (int i = 0; i < ppcp_pkg::FRAC_BITS; i++) begin
        r = r << 1;
        mq = mq << 1;
        if (r >= nh) begin
          r = r - nh;
          mq = mq | 1;
        end
      end
      if (mq > STEP_LIM) mq = STEP_LIM;
    end
    return ((g < 0) == (h < 0)) ? -longint'(mq) : longint'(mq);
  endfunction

  function automatic ppcp_pkg::ppcp_out_t closest_point(logic signed [31:0] px,
                                                       logic signed [31:0] py);
    longint cx [ppcp_pkg::NCOEF];
    longint cy [ppcp_pkg::NCOEF];
    longint dsq [2 * ppcp_pkg::MAX_ORDER + 1];
    longint slope [ppcp_pkg::NSCR];
    longint s, g, h, delta;
    int order;
    bit done;
    ppcp_pkg::ppcp_out_t res;
    order = order_reg < ppcp_pkg::MAX_ORDER ? order_reg : ppcp_pkg::MAX_ORDER;
    for (int i = 0; i < ppcp_pkg::NCOEF; i++) begin
      if (i > order) begin
        cx[i] = 0;
        cy[i] = 0;
      end else if (i == 0) begin
        cx[i] = offset(x_tab[0], px);
        cy[i] = offset(y_tab[0], py);
      end else begin
        cx[i] = x_tab[i];
        cy[i] = y_tab[i];
      end
    end
    foreach (dsq[i]) dsq[i] = 0;
    for (int i = 0; i < ppcp_pkg::NCOEF; i++)
      for (int j = 0; j < ppcp_pkg::NCOEF; j++)
        dsq[i + j] = add_sat(dsq[i + j],
                             add_sat(frac_prod(cx[i], cx[j]), frac_prod(cy[i], cy[j])));
    for (int i = 0; i < ppcp_pkg::NSCR; i++) slope[i] = times_k(dsq[i + 1], i + 1);
    s = 0;
    done = 0;
    for (int it = 0; !done && it < iter_reg; it++) begin
      g = slope[ppcp_pkg::NSCR - 1];
      h = 0;
      for (int k = ppcp_pkg::NSCR - 2; k >= 0; k--) begin
        g = add_sat(mul_frac(g, s), slope[k]);
        h = add_sat(mul_frac(h, s), times_k(slope[k + 1], k + 1));
      end
      delta = newton_delta(g, h);
      s = s + delta;
      if (s < 0) s = 0;
      if (s > longint'(length_reg)) s = length_reg;
      if (absu(delta) < 64'(tol_reg)) done = 1;
    end
    res.path_param = s[30:0];
    res.converged = done;
    return res;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    ppcp_pkg::ppcp_out_t want;
    if (!rst_n) begin
      foreach (x_tab[i]) begin
        x_tab[i] = 0;
        y_tab[i] = 0;
      end
      length_reg = 0;
      tol_reg = 25'd16777;
      iter_reg = 8'd100;
      order_reg = 3'd5;
      answers_due.delete();
    end else begin
      if (out_valid) begin
        if (answers_due.size() == 0) begin
          report("unexpected result, path_param", out_item.path_param, -1);
        end else begin
          want = answers_due.pop_front();
          if (out_item.path_param !== want.path_param)
            report("path_param", out_item.path_param, want.path_param);
          if (out_item.converged !== want.converged)
            report("converged", out_item.converged, want.converged);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          ppcp_pkg::REG_PATH_LENGTH:    length_reg = cfg_wdata;
          ppcp_pkg::REG_STOP_TOLERANCE: tol_reg = cfg_wdata[24:0];
          ppcp_pkg::REG_MAX_ITERATIONS: iter_reg = cfg_wdata[7:0];
          ppcp_pkg::REG_PATH_ORDER:     order_reg = cfg_wdata[2:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_item.opcode == ppcp_pkg::OP_QUERY) begin
          answers_due = {answers_due, closest_point(in_item.pos_x, in_item.pos_y)};
        end else if (in_item.coef_index <= ppcp_pkg::MAX_ORDER) begin
          if (in_item.axis == ppcp_pkg::AXIS_Y) y_tab[in_item.coef_index] = in_item.coef_value;
          else x_tab[in_item.coef_index] = in_item.coef_value;
        end
      end
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the closest point block. All prediction and comparison
// lives in the checker instance; this module only drives commands and registers.
module tb_top;

  // Upper bound on cycles without any transfer. The slowest query runs 255 Newton
  // steps, which this bound covers with a wide margin.
  localparam int IDLE_LIMIT = 200000;
  localparam logic [30:0] ONE_Q = 31'h0100_0000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  ppcp_pkg::ppcp_in_t  in_item;
  logic                out_valid;
  ppcp_pkg::ppcp_out_t out_item;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  logic [30:0]         cfg_wdata;
  int                  errors;
  int                  pending;
  int                  idle_cycles;

  polynomial_path_closest_point DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  closest_point_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // The watchdog restarts its count whenever a command or a result transfer occurs.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Random coefficient: usually a modest value so Newton has something sensible to
  // chase, sometimes a full-width word so every bit of the field toggles.
  function automatic logic signed [31:0] coef_rand();
    if ($urandom_range(0, 5) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
  endfunction

  function automatic ppcp_pkg::ppcp_in_t write_cmd(logic ax, logic [2:0] idx,
                                                   logic signed [31:0] v);
    ppcp_pkg::ppcp_in_t c;
    c.pos_x = $urandom;
    c.pos_y = $urandom;
    c.opcode = ppcp_pkg::OP_WRITE;
    c.axis = ax;
    c.coef_index = idx;
    c.coef_value = v;
    return c;
  endfunction

  function automatic ppcp_pkg::ppcp_in_t query_cmd(logic signed [31:0] px,
                                                   logic signed [31:0] py);
    ppcp_pkg::ppcp_in_t c;
    c.axis = 1'($urandom);
    c.coef_index = 3'($urandom);
    c.coef_value = $urandom;
    c.opcode = ppcp_pkg::OP_QUERY;
    c.pos_x = px;
    c.pos_y = py;
    return c;
  endfunction

  // Presents one command and returns right after the edge that takes it. busy only
  // changes at rising edges, so looking at it on the falling edge is race free.
  task automatic send(ppcp_pkg::ppcp_in_t c);
    start <= 1'b1;
    in_item <= c;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  task automatic maybe_pause();
    int r;
    int n;
    r = $urandom_range(0, 9);
    n = r < 6 ? 0 : (r < 9 ? $urandom_range(1, 3) : $urandom_range(10, 40));
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Holds off until every answer has come back and the block is idle, then gives a
  // trailing coefficient write time to settle.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  // Writes one register and leaves the write enable high for a following write.
  task automatic put_reg(logic [1:0] idx, logic [30:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [30:0] v);
    put_reg(idx, v);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(logic [30:0] len, logic [30:0] tol, logic [30:0] iters,
                         logic [30:0] order);
    drain();
    put_reg(ppcp_pkg::REG_PATH_LENGTH, len);
    put_reg(ppcp_pkg::REG_STOP_TOLERANCE, tol);
    put_reg(ppcp_pkg::REG_MAX_ITERATIONS, iters);
    set_reg(ppcp_pkg::REG_PATH_ORDER, order);
  endtask

  // A well-formed burst: a handful of coefficient writes describing a path, then one or two
  // queries at modest positions. Occasionally a pure-noise command is mixed in.
  task automatic path_burst();
    int nw;
    nw = $urandom_range(1, 6);
    repeat (nw) begin
      send(write_cmd(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), coef_rand()));
      maybe_pause();
    end
    repeat ($urandom_range(1, 2)) begin
      if ($urandom_range(0, 7) == 0) send(query_cmd($urandom, $urandom));
      else send(query_cmd(coef_rand(), coef_rand()));
      maybe_pause();
    end
  endtask

  initial begin
    logic [30:0] len;
    logic [30:0] tol;
    logic [30:0] iters;
    logic [30:0] order;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. First a query with reset registers: zero path length pins s at 0.
    send(query_cmd(32'sh0100_0000, -32'sh0100_0000));
    set_all(31'(4) * ONE_Q, 31'd16777, 31'd20, 31'd5);
    // A straight line x = s, y = 0 queried at x = 1.5: a quadratic distance.
    send(write_cmd(ppcp_pkg::AXIS_X, 3'd1, 32'sh0100_0000));
    send(query_cmd(32'sh0180_0000, 32'sh0000_0000));
    // Query beyond the end of the path, and behind its start, to hit both clamps.
    send(query_cmd(32'sh0A00_0000, 32'sh0000_0000));
    send(query_cmd(-32'sh0300_0000, 32'sh0000_0000));
    // Indexes past the highest order are ignored by the block.
    send(write_cmd(ppcp_pkg::AXIS_Y, 3'd6, 32'sh7FFF_FFFF));
    send(write_cmd(ppcp_pkg::AXIS_X, 3'd7, 32'sh8000_0000));
    // A parabola y = s^2 with the position at the extremes of the field.
    send(write_cmd(ppcp_pkg::AXIS_Y, 3'd2, 32'sh0100_0000));
    send(query_cmd(32'sh7FFF_FFFF, 32'sh8000_0000));
    send(query_cmd(32'sh8000_0000, 32'sh7FFF_FFFF));
    // Extreme coefficients drive the saturating arithmetic.
    send(write_cmd(ppcp_pkg::AXIS_X, 3'd5, 32'sh7FFF_FFFF));
    send(write_cmd(ppcp_pkg::AXIS_Y, 3'd0, 32'sh8000_0000));
    send(query_cmd(32'sh0000_0000, 32'sh0000_0000));
    // A constant path: no slope anywhere, every step is zero.
    set_all(ONE_Q, 31'd0, 31'd255, 31'd0);
    send(query_cmd(32'sh0100_0000, 32'sh0100_0000));
    // A zero iteration limit takes no step at all.
    set_all(31'h7FFF_FFFF, 31'd16777216, 31'd0, 31'd1);
    send(query_cmd(32'sh0200_0000, 32'sh0000_0000));
    // Zero tolerance never converges; order 7 is cut back to the highest order.
    set_all(31'(2) * ONE_Q, 31'h7FFF_FFFF, 31'd255, 31'd7);
    send(query_cmd(32'sh0080_0000, -32'sh0080_0000));
    drain();
    set_reg(ppcp_pkg::REG_STOP_TOLERANCE, 31'd0);
    send(write_cmd(ppcp_pkg::AXIS_X, 3'd5, 32'sh0000_0000));
    send(write_cmd(ppcp_pkg::AXIS_Y, 3'd0, 32'sh0000_0000));
    send(query_cmd(32'sh0080_0000, 32'sh0040_0000));

    // Random part in phases, each starting from idle with fresh register values.
    // The drain before each phase makes the sender wait for every pending answer.
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 3))
        0: len = 31'($urandom);
        1: len = 31'h7FFF_FFFF;
        default: len = 31'($urandom_range(0, 8)) * ONE_Q +
                       31'($urandom_range(0, 32'hFF_FFFF));
      endcase
      case ($urandom_range(0, 3))
        0: tol = 31'd0;
        1: tol = 31'd16777216;
        2: tol = 31'($urandom);
        default: tol = 31'($urandom_range(1, 200000));
      endcase
      // Most phases allow few steps so the run stays short; one reaches the top.
      iters = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'd0;
      iters[7:0] = (ph == 5) ? 8'd255 : 8'($urandom_range(1, 24));
      order = ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'($urandom_range(0, 5));
      set_all(len, tol, iters, order);
      repeat (2) path_burst();
    end

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/ppcp_pkg.sv
rtl/ppcp_div.sv
rtl/polynomial_path_closest_point.sv
tb/closest_point_checker.sv
tb/tb_top.sv
